// ----- src/ess_pkg.sv -----
// Package for the exchange sort engine: element type, widths and shared
// control structs. No dependencies.
package ess_pkg;

    localparam int VALUE_W = 16;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Back end tells the front end that a store bank may be refilled.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

// ----- src/ess_if.sv -----
// Handshake interfaces for the exchange sort engine's input and result channels.
// Depends on ess_pkg.
interface ess_in_if import ess_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value value;
    logic   is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink (input valid, input value, input is_last, output ready);
endinterface

interface ess_out_if import ess_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value sorted_value;
    logic   final_res;
    logic   dropped;

    modport source (output valid, output sorted_value, output final_res, output dropped,
                    input ready);
    modport sink (input valid, input sorted_value, input final_res, input dropped,
                  output ready);
endinterface

// ----- src/ess_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ess_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/ess_queue.sv -----
// Two-entry queue of batch descriptors between the front and back ends.
// No dependencies.
module ess_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
endmodule

// ----- src/ess_front.sv -----
// Front end: accepts requests, appends values to the current store bank and
// hands a finished batch to the queue. Depends on ess_pkg and ess_if.
module ess_front import ess_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ess_in_if.sink                     i_in,
    input  t_release                   i_release,
    output logic                       o_we,
    output logic                       o_wbank,
    output logic [$clog2(DEPTH)-1:0]   o_waddr,
    output t_value                     o_wdata,
    output logic                       o_push,
    output logic [$clog2(DEPTH+1)+1:0] o_desc
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic          r_wbank;
    logic [CW-1:0] r_cnt;
    logic          r_ovf;
    logic [1:0]    r_busy;
    logic [1:0]    n_busy;
    logic          accept;
    logic          room;
    logic [CW-1:0] cnt_after;
    logic          ovf_after;

    assign i_in.ready = !r_busy[r_wbank];
    assign accept     = i_in.valid && i_in.ready;
    assign room       = (r_cnt < CW'(DEPTH));
    assign cnt_after  = room ? CW'(r_cnt + 1'b1) : r_cnt;
    assign ovf_after  = r_ovf | !room;

    assign o_we    = accept && room;
    assign o_wbank = r_wbank;
    assign o_waddr = r_cnt[AW-1:0];
    assign o_wdata = i_in.value;
    assign o_push  = accept && i_in.is_last;
    assign o_desc  = {r_wbank, cnt_after, ovf_after};

    always_comb begin
        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (o_push) begin
            n_busy[r_wbank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbank <= 1'b0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_busy  <= 2'b00;
        end else begin
            r_busy <= n_busy;
            if (accept) begin
                if (i_in.is_last) begin
                    r_cnt   <= '0;
                    r_ovf   <= 1'b0;
                    r_wbank <= ~r_wbank;
                end else begin
                    r_cnt <= cnt_after;
                    r_ovf <= ovf_after;
                end
            end
        end
    end
endmodule

// ----- src/ess_back.sv -----
// Back end: sorts one stored batch by exchange passes and emits it through
// an output register. Depends on ess_pkg and ess_if.
module ess_back import ess_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  logic [$clog2(DEPTH+1)+1:0] i_q_desc,
    output logic                       o_pop,
    output logic                       o_bank,
    output logic                       o_re,
    output logic [$clog2(DEPTH)-1:0]   o_raddr,
    input  t_value                     i_rdata,
    output logic                       o_we,
    output logic [$clog2(DEPTH)-1:0]   o_waddr,
    output t_value                     o_wdata,
    output t_release                   o_release,
    ess_out_if.source                  o_out
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD_I = 3'd1;
    localparam logic [2:0] ST_LD_I = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]    r_state, n_state;
    logic          r_bank, n_bank;
    logic [CW-1:0] r_n, n_n;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    t_value        r_cur, n_cur;
    logic          r_ov, n_ov;
    t_value        r_val, n_val;
    logic          r_fin, n_fin;
    logic          r_drop, n_drop;
    logic [CW-1:0] i_next;
    logic [CW-1:0] j_next;

    assign i_next = CW'(r_i + 1'b1);
    assign j_next = CW'(r_j + 1'b1);

    always_comb begin
        n_state   = r_state;
        n_bank    = r_bank;
        n_n       = r_n;
        n_ovf     = r_ovf;
        n_i       = r_i;
        n_j       = r_j;
        n_cur     = r_cur;
        n_ov      = r_ov && !o_out.ready;
        n_val     = r_val;
        n_fin     = r_fin;
        n_drop    = r_drop;
        o_pop     = 1'b0;
        o_re      = 1'b0;
        o_raddr   = r_i[AW-1:0];
        o_we      = 1'b0;
        o_waddr   = r_j[AW-1:0];
        o_wdata   = r_cur;
        o_release = '{valid: 1'b0, bank: r_bank};
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_bank  = i_q_desc[CW+1];
                    n_n     = i_q_desc[CW:1];
                    n_ovf   = i_q_desc[0];
                    n_i     = '0;
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: begin
                o_re    = 1'b1;
                o_raddr = r_i[AW-1:0];
                n_state = ST_LD_I;
            end
            ST_LD_I: begin
                n_cur = i_rdata;
                n_j   = i_next;
                if (i_next < r_n) begin
                    o_re    = 1'b1;
                    o_raddr = i_next[AW-1:0];
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SCAN: begin
                // A smaller later element takes the place of the running minimum.
                if (i_rdata < r_cur) begin
                    o_we    = 1'b1;
                    o_waddr = r_j[AW-1:0];
                    o_wdata = r_cur;
                    n_cur   = i_rdata;
                end
                if (j_next < r_n) begin
                    o_re    = 1'b1;
                    o_raddr = j_next[AW-1:0];
                    n_j     = j_next;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov   = 1'b1;
                    n_val  = r_cur;
                    n_fin  = (i_next == r_n);
                    n_drop = r_ovf;
                    if (i_next == r_n) begin
                        o_release = '{valid: 1'b1, bank: r_bank};
                        n_state   = ST_IDLE;
                    end else begin
                        n_i     = i_next;
                        n_state = ST_RD_I;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bank <= n_bank;
        r_n    <= n_n;
        r_ovf  <= n_ovf;
        r_i    <= n_i;
        r_j    <= n_j;
        r_cur  <= n_cur;
        r_val  <= n_val;
        r_fin  <= n_fin;
        r_drop <= n_drop;
    end

    assign o_bank             = r_bank;
    assign o_out.valid        = r_ov;
    assign o_out.sorted_value = r_val;
    assign o_out.final_res    = r_fin;
    assign o_out.dropped      = r_drop;
endmodule

// ----- src/exchange_sort_engine.sv -----
// Exchange sort engine: batch sorter for signed 16-bit values.
// Depends on ess_pkg, ess_if, ess_ram, ess_queue, ess_front and ess_back.
//
// Input channel i_in carries one value per request; a request with is_last set
// closes the batch. Up to DEPTH values are kept; further values of the same
// batch are discarded and every result of that batch then carries dropped.
// Results leave on o_out, smallest first, with final_res on the last one.
// Requests that do not close a batch produce no results.
//
// The store has two banks. While the back end sorts and emits one batch, the
// front end loads the next into the other bank; the input stalls only when
// both banks hold batches still waiting to be emitted.
// Each sorting pass fetches its first value, scans the remaining values with one
// store read per cycle, then places the pass minimum in the output register.
// A stalled receiver simply holds the output register; sorting waits on it.
// Reset empties both banks, the queue and the output register.
module exchange_sort_engine import ess_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ess_in_if.sink    i_in,
    ess_out_if.source o_out
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = CW + 2;

    logic          f_we;
    logic          f_wbank;
    logic [AW-1:0] f_waddr;
    t_value        f_wdata;
    logic          q_push;
    logic [DW-1:0] q_wdesc;
    logic          q_valid;
    logic [DW-1:0] q_rdesc;
    logic          b_pop;
    logic          b_bank;
    logic          b_re;
    logic [AW-1:0] b_raddr;
    logic          b_we;
    logic [AW-1:0] b_waddr;
    t_value        b_wdata;
    t_release      release_req;
    t_value        bank_rdata [2];

    ess_front #(.DEPTH(DEPTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_release (release_req),
        .o_we      (f_we),
        .o_wbank   (f_wbank),
        .o_waddr   (f_waddr),
        .o_wdata   (f_wdata),
        .o_push    (q_push),
        .o_desc    (q_wdesc)
    );

    ess_queue #(.WIDTH(DW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdesc),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_data  (q_rdesc)
    );

    ess_back #(.DEPTH(DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_desc  (q_rdesc),
        .o_pop     (b_pop),
        .o_bank    (b_bank),
        .o_re      (b_re),
        .o_raddr   (b_raddr),
        .i_rdata   (bank_rdata[b_bank]),
        .o_we      (b_we),
        .o_waddr   (b_waddr),
        .o_wdata   (b_wdata),
        .o_release (release_req),
        .o_out     (o_out)
    );

    // The front end only ever writes a bank that the back end has released,
    // so each bank's single write port is shared without conflict.
    for (genvar k = 0; k < 2; k++) begin : g_bank
        logic          front_sel;
        logic          we;
        logic [AW-1:0] waddr;
        t_value        wdata;
        logic          re;
        logic [VALUE_W-1:0] rdata;

        assign front_sel = f_we && (f_wbank == 1'(k));
        assign we        = front_sel || (b_we && (b_bank == 1'(k)));
        assign waddr     = front_sel ? f_waddr : b_waddr;
        assign wdata     = front_sel ? f_wdata : b_wdata;
        assign re        = b_re && (b_bank == 1'(k));

        ess_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (re),
            .i_raddr (b_raddr),
            .o_rdata (rdata)
        );

        assign bank_rdata[k] = t_value'(rdata);
    end
endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for exchange_sort_engine: random and directed batches of signed values.
// It predicts every sorted run itself and checks each result in order, under random stalls.
// Depends on ess_pkg, ess_if and the exchange_sort_engine RTL.
module tb_top;
    import ess_pkg::*;

    localparam int DEPTH      = 16;
    localparam int LONG_HOLD  = 400;     // receiver hold-off in cycles, long enough to fill both banks
    localparam int CALM_TAIL  = 50;      // final requests sent with no idling on either side
    localparam int TAIL_WAIT  = 200;     // extra wait after the last expected result, before the verdict
    localparam int LIMIT      = 300000;

    // One request waiting to be offered on the input channel.
    typedef struct {
        t_value value;
        logic   is_last;
        bit     wait_empty;   // hold the request back until every sorted value is out
        bit     start_hold;   // once taken, the receiver holds off for a long stretch
    } t_request;

    // One expected result of a sorted batch.
    typedef struct {
        t_value value;
        logic   final_res;
        logic   dropped;
    } t_sorted;

    logic clk;
    logic rst_n;

    ess_in_if  in_ch ();
    ess_out_if out_ch ();

    exchange_sort_engine #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_request pending[$];
    t_sorted  sorted_expect[$];
    t_value   batch_vals[$];      // values held for the open batch, in arrival order
    bit       batch_lost;         // a value of the open batch did not fit

    t_request on_bus;
    int       gap_left;
    int       stall_left;
    int       hold_left;
    logic     hold_kick;
    int       taken;
    int       n_requests;
    int       n_batches;
    int       n_overflow;
    int       n_checked;
    int       n_errors;
    int       cycles;
    bit       calm;

    // Clock and the single reset at the start of the run.
    initial begin
        clk   = 1'b0;
        rst_n = 1'b0;
        fork
            forever #5 clk = ~clk;
            begin
                repeat (7) @(posedge clk);
                rst_n <= 1'b1;
            end
        join_none
    end

    task automatic flag_mismatch(input string msg);
        if (n_errors < 100)
            $display("MISMATCH at cycle %0d: %s", cycles, msg);
        n_errors++;
    endtask

    // Appends one value to the open batch, or marks the batch lost once it is full; a closing
    // request sorts the batch by pairwise exchange and queues every value it will emit.
    task automatic absorb_request(input t_value v, input logic last);
        t_value tmp;
        int     n;
        if (batch_vals.size() < DEPTH)
            batch_vals = {batch_vals, v};
        else
            batch_lost = 1'b1;
        if (last) begin
            n = batch_vals.size();
            for (int i = 0; i < n; i++) begin
                for (int j = i + 1; j < n; j++) begin
                    if (batch_vals[i] > batch_vals[j]) begin
                        tmp           = batch_vals[i];
                        batch_vals[i] = batch_vals[j];
                        batch_vals[j] = tmp;
                    end
                end
            end
            for (int k = 0; k < n; k++)
                sorted_expect = {sorted_expect,
                                 t_sorted'{batch_vals[k], logic'(k == n - 1), batch_lost}};
            n_batches++;
            if (batch_lost)
                n_overflow++;
            batch_vals.delete();
            batch_lost = 1'b0;
        end
    endtask

    // Queues one batch of n requests. Styles: 0 full range, 1 narrow range with many
    // duplicates, 2 rising run, 3 falling run.
    task automatic queue_batch(input int n, input int style, input bit wait_empty,
                               input bit start_hold);
        t_request r;
        int       base;
        int       step;
        base = $urandom_range(0, 65535);
        step = $urandom_range(1, 300);
        for (int k = 0; k < n; k++) begin
            case (style)
                1: r.value = t_value'($urandom_range(0, 8) - 4);
                2: r.value = t_value'(base + k * step);
                3: r.value = t_value'(base - k * step);
                default: r.value = t_value'($urandom_range(0, 65535));
            endcase
            r.is_last    = (k == n - 1);
            r.wait_empty = wait_empty && (k == 0);
            r.start_hold = start_hold && (k == 0);
            pending = {pending, r};
        end
    endtask

    // Stimulus plan, then the end-of-run wait and verdict.
    initial begin
        t_request r;
        int       sz;
        in_ch.valid   = 1'b0;
        in_ch.value   = '0;
        in_ch.is_last = 1'b0;
        out_ch.ready  = 1'b0;
        batch_lost    = 1'b0;
        hold_kick     = 1'b0;

        r.wait_empty = 1'b0;
        r.start_hold = 1'b0;
        // A batch of one value at each extreme.
        r.value = t_value'(16'sh8000); r.is_last = 1'b1; pending = {pending, r};
        r.value = t_value'(16'sh7FFF); r.is_last = 1'b1; pending = {pending, r};
        // Mixed signs around zero, closing request not the largest.
        r.is_last = 1'b0;
        r.value = 16'sh7FFF; pending = {pending, r};
        r.value = 16'sh8000; pending = {pending, r};
        r.value = 16'sh0000; pending = {pending, r};
        r.value = 16'shFFFF; pending = {pending, r};
        r.value = 16'sh0001; r.is_last = 1'b1; pending = {pending, r};
        // Duplicates must all come out, and equal values are never exchanged.
        r.is_last = 1'b0;
        r.value = 16'sd7;  pending = {pending, r};
        r.value = -16'sd7; pending = {pending, r};
        r.value = 16'sd7;  pending = {pending, r};
        r.value = -16'sd7; r.is_last = 1'b1; pending = {pending, r};
        // Store full: seventeen falling values, the closing one is discarded yet still
        // triggers the sort, and every result of the batch is flagged.
        for (int k = 0; k < 17; k++) begin
            r.value   = t_value'(1000 - 37 * k);
            r.is_last = (k == 16);
            pending = {pending, r};
        end

        // Random batches, mostly partial, some exactly full, some overflowing.
        while (pending.size() < 300) begin
            case ($urandom_range(0, 9))
                0:       sz = DEPTH;
                1:       sz = $urandom_range(DEPTH + 1, DEPTH + 4);
                default: sz = $urandom_range(1, DEPTH - 1);
            endcase
            queue_batch(sz, $urandom_range(0, 3), $urandom_range(0, 7) == 0, 1'b0);
        end
        // Once the backlog has drained, the receiver holds off while full batches keep arriving,
        // so both banks fill and the input stalls.
        queue_batch(DEPTH, 0, 1'b1, 1'b1);
        for (int b = 0; b < 4; b++)
            queue_batch(DEPTH, $urandom_range(0, 3), 1'b0, 1'b0);
        // Quiet tail.
        while (pending.size() < 430)
            queue_batch($urandom_range(1, DEPTH + 2), $urandom_range(0, 3), 1'b0, 1'b0);
        n_requests = pending.size();

        wait (rst_n === 1'b1);
        while (pending.size() > 0 || in_ch.valid)
            @(negedge clk);
        while (sorted_expect.size() > 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(negedge clk);
        if (sorted_expect.size() > 0 || batch_vals.size() > 0)
            flag_mismatch($sformatf("%0d sorted values never arrived", sorted_expect.size()));
        $display("Sent %0d requests in %0d batches, %0d of them overflowing the store;",
                 taken, n_batches, n_overflow);
        $display("checked %0d sorted values with %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0)
            $display("exchange_sort_engine test passed");
        else
            $display("exchange_sort_engine test failed");
        $finish;
    end

    // Input driver: takes requests from the pending queue, predicts on acceptance and
    // inserts idle bursts until the quiet tail.
    always @(posedge clk) begin
        bit offer;
        bit kick;
        if (!rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.value   <= '0;
            in_ch.is_last <= 1'b0;
            hold_kick     <= 1'b0;
            gap_left      = 0;
        end else begin
            kick = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                absorb_request(in_ch.value, in_ch.is_last);
                taken++;
                kick = on_bus.start_hold;
                calm = (taken + CALM_TAIL >= n_requests);
            end
            // A request on offer but not yet taken stays exactly as it is.
            if (!(in_ch.valid && !in_ch.ready)) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() > 0 &&
                             !(pending[0].wait_empty && sorted_expect.size() > 0)) begin
                    if (!calm && $urandom_range(0, 4) == 0) begin
                        gap_left = $urandom_range(0, 2);
                    end else begin
                        on_bus = pending.pop_front();
                        offer  = 1'b1;
                    end
                end
                in_ch.valid <= offer;
                if (offer) begin
                    in_ch.value   <= on_bus.value;
                    in_ch.is_last <= on_bus.is_last;
                end
            end
            hold_kick <= kick;
        end
    end

    // Long receiver hold-off, counted here and started by the driver.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_kick) begin
            hold_left <= LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: checks every accepted result against the oldest expectation and
    // drives ready with random stall bursts.
    always @(posedge clk) begin
        t_sorted want;
        bit      go;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_checked++;
                if (sorted_expect.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result value=%0d final=%b dropped=%b",
                                  out_ch.sorted_value, out_ch.final_res, out_ch.dropped));
                end else begin
                    want = sorted_expect.pop_front();
                    if (out_ch.sorted_value !== want.value || out_ch.final_res !== want.final_res
                        || out_ch.dropped !== want.dropped)
                        flag_mismatch($sformatf(
                            "got value=%0d final=%b dropped=%b, want value=%0d final=%b dropped=%b",
                            out_ch.sorted_value, out_ch.final_res, out_ch.dropped,
                            want.value, want.final_res, want.dropped));
                end
            end
            if (hold_left > 0) begin
                go = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                go = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                go = 1'b0;
            end else begin
                go = 1'b1;
            end
            out_ch.ready <= go;
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Timed out after %0d cycles with %0d sorted values outstanding.",
                     cycles, sorted_expect.size());
            $display("exchange_sort_engine test failed");
            $finish;
        end
    end

endmodule
